FILE: rtl/mcss_pkg.sv
// shared types, constants and helpers for the sonar sequencer
package mcss_pkg;

    localparam int NUM_CHANNELS = 4;
    localparam int CH_W = (NUM_CHANNELS > 2) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [7:0] NO_ECHO_CM = 8'd255;

    localparam logic OP_TIMER = 1'b0;
    localparam logic OP_ECHO  = 1'b1;

    localparam logic REG_SCALE = 1'b0;
    localparam logic REG_SHIFT = 1'b1;

    localparam logic [15:0] SCALE_RESET = 16'd256;
    localparam logic [3:0]  SHIFT_RESET = 4'd8;

    typedef logic [CH_W-1:0] t_ch;

    typedef enum logic [1:0] {
        PH_LISTEN = 2'd0,
        PH_BURST  = 2'd1,
        PH_DECAY  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        WAIT_LISTEN = 2'd0,
        WAIT_BURST  = 2'd1,
        WAIT_DECAY  = 2'd2,
        WAIT_NONE   = 2'd3
    } t_wait;

    typedef struct packed {
        logic        op;
        logic [15:0] capture_count;
    } t_in;

    typedef struct packed {
        logic [1:0] mux_channel;
        logic [1:0] report_channel;
        logic [7:0] distance_cm;
        logic       distance_valid;
        logic       burst_on;
        t_wait      wait_select;
        logic       restart_echo_timer;
        logic       cycle_done;
    } t_out;

    // low two bits of a channel number, zero extended when the count is small
    function automatic logic [1:0] ch_out(input t_ch c);
        logic [CH_W+1:0] e;
        e = {2'b00, c};
        return e[1:0];
    endfunction

endpackage

FILE: rtl/mcss_range.sv
// echo time to distance: scale, shift and saturate
module mcss_range (
    input  logic [15:0] i_capture,
    input  logic [15:0] i_scale,
    input  logic [3:0]  i_shift,
    output logic [7:0]  o_dist
);

    logic [31:0] prod;
    logic [31:0] shifted;

    always_comb begin
        prod    = {16'd0, i_capture} * {16'd0, i_scale};
        shifted = prod >> i_shift;
        if (|shifted[31:8]) begin
            o_dist = mcss_pkg::NO_ECHO_CM;
        end else begin
            o_dist = shifted[7:0];
        end
    end

endmodule

FILE: rtl/mcss_seq.sv
// phase and channel sequencer, builds one result per event
module mcss_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  logic             i_op,
    input  logic [7:0]       i_dist,
    output mcss_pkg::t_out   o_res
);

    mcss_pkg::t_phase r_phase, n_phase;
    mcss_pkg::t_ch    r_channel, n_channel;
    logic             r_echo_seen, n_echo_seen;
    logic             r_armed, n_armed;

    mcss_pkg::t_ch    ch_inc;
    logic             ch_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= mcss_pkg::PH_LISTEN;
            r_channel   <= '0;
            r_echo_seen <= 1'b0;
            r_armed     <= 1'b0;
        end else if (i_adv) begin
            r_phase     <= n_phase;
            r_channel   <= n_channel;
            r_echo_seen <= n_echo_seen;
            r_armed     <= n_armed;
        end
    end

    always_comb begin
        ch_last = (r_channel == mcss_pkg::CH_W'(mcss_pkg::NUM_CHANNELS - 1));
        ch_inc  = ch_last ? '0 : r_channel + mcss_pkg::CH_W'(1);

        n_phase     = r_phase;
        n_channel   = r_channel;
        n_echo_seen = r_echo_seen;
        n_armed     = r_armed;

        o_res.report_channel     = mcss_pkg::ch_out(r_channel);
        o_res.distance_cm        = 8'd0;
        o_res.distance_valid     = 1'b0;
        o_res.burst_on           = 1'b0;
        o_res.wait_select        = mcss_pkg::WAIT_NONE;
        o_res.restart_echo_timer = 1'b0;
        o_res.cycle_done         = 1'b0;

        if (i_op == mcss_pkg::OP_TIMER) begin
            case (r_phase)
                mcss_pkg::PH_LISTEN: begin
                    n_armed = 1'b0;
                    if (!r_echo_seen) begin
                        // missed echo
                        o_res.distance_cm    = mcss_pkg::NO_ECHO_CM;
                        o_res.distance_valid = 1'b1;
                        o_res.cycle_done     = ch_last;
                        n_channel            = ch_inc;
                    end else begin
                        n_echo_seen = 1'b0;
                    end
                    o_res.restart_echo_timer = 1'b1;
                    o_res.burst_on           = 1'b1;
                    o_res.wait_select        = mcss_pkg::WAIT_BURST;
                    n_phase                  = mcss_pkg::PH_BURST;
                end
                mcss_pkg::PH_BURST: begin
                    o_res.wait_select = mcss_pkg::WAIT_DECAY;
                    n_phase           = mcss_pkg::PH_DECAY;
                end
                mcss_pkg::PH_DECAY: begin
                    n_armed           = 1'b1;
                    o_res.wait_select = mcss_pkg::WAIT_LISTEN;
                    n_phase           = mcss_pkg::PH_LISTEN;
                end
                default: begin
                    o_res.wait_select = mcss_pkg::WAIT_LISTEN;
                    n_phase           = mcss_pkg::PH_LISTEN;
                end
            endcase
        end else if (r_armed) begin
            // first echo of the window
            n_armed              = 1'b0;
            n_echo_seen          = 1'b1;
            o_res.distance_cm    = i_dist;
            o_res.distance_valid = 1'b1;
            o_res.cycle_done     = ch_last;
            n_channel            = ch_inc;
        end

        o_res.mux_channel = mcss_pkg::ch_out(n_channel);
    end

endmodule

FILE: rtl/multi_channel_sonar_sequencer_core.sv
// top level of the four-transducer sonar event sequencer
//
// Event sequencer for a multi-transducer ultrasonic ranger. Each input
// transaction is one event: a phase timer expiry or an echo capture. Every
// event yields exactly one output transaction carrying the selected channel,
// an optional distance, the burst drive enable and the next wait to load.
// An event passes through an input register and the sequencer/range logic
// into the output register. One event is taken every cycle unless a held
// result stalls the input; the critical path is the 16x16 multiply followed by
// the barrel shift and saturation. cm_scale lives at byte address 0 and
// cm_shift at address 4; write them only while no events are in flight.
module multi_channel_sonar_sequencer_core (
    input  logic            i_clk,
    input  logic            i_rst_n,

    // event channel
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  mcss_pkg::t_in   i_in_data,

    // result channel
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output mcss_pkg::t_out  o_out_data,

    // register port
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [2:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    // configuration registers
    logic [15:0] r_cm_scale;
    logic [3:0]  r_cm_shift;
    logic        cfg_wr;

    // input stage
    logic           r_in_valid;
    mcss_pkg::t_in  r_in;

    // output stage
    logic           r_out_valid;
    mcss_pkg::t_out r_out;

    logic           out_free;
    logic           adv;
    logic           in_take;
    logic [7:0]     range_cm;
    mcss_pkg::t_out res;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cm_scale <= mcss_pkg::SCALE_RESET;
            r_cm_shift <= mcss_pkg::SHIFT_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == mcss_pkg::REG_SCALE) begin
                r_cm_scale <= pwdata[15:0];
            end else begin
                r_cm_shift <= pwdata[3:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == mcss_pkg::REG_SCALE) begin
            prdata = {16'd0, r_cm_scale};
        end else begin
            prdata = {28'd0, r_cm_shift};
        end
    end

    // the output register frees when empty or being taken this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    mcss_range u_range (
        .i_capture (r_in.capture_count),
        .i_scale   (r_cm_scale),
        .i_shift   (r_cm_shift),
        .o_dist    (range_cm)
    );

    // state advances only when the event moves into the output register
    mcss_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_op    (r_in.op),
        .i_dist  (range_cm),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // an event moved on always leaves a result behind
    a_adv_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("result register empty after an event moved on");

    // the input side only stalls behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall && r_in_valid))
        else $error("input stalled without a held result");

    // a burst start always restarts the echo timer with the burst wait
    a_burst_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.burst_on) |->
            (r_out.restart_echo_timer && r_out.wait_select == mcss_pkg::WAIT_BURST))
        else $error("burst start without timer restart");

    // a finished cycle always carries a distance
    a_done_has_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.cycle_done) |-> r_out.distance_valid)
        else $error("cycle done without a distance");

endmodule

FILE: test/tb.sv
// testbench for the sonar event sequencer: directed and random events, self-checking
`timescale 1ns / 1ps

module tb;

    // pipeline latency, plus a little slack before touching the registers
    localparam int LATENCY       = 2;
    localparam int SETTLE_CYCLES = LATENCY + 4;

    // clock, reset and every input of the block start at a known value
    logic           i_clk;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           o_in_stall;
    mcss_pkg::t_in  i_in_data   = '0;
    logic           o_out_valid;
    logic           i_out_stall = 1'b0;
    mcss_pkg::t_out o_out_data;
    logic           psel        = 1'b0;
    logic           penable     = 1'b0;
    logic           pwrite      = 1'b0;
    logic [2:0]     paddr       = '0;
    logic [31:0]    pwdata      = '0;
    logic [31:0]    prdata;
    logic           pready;

    multi_channel_sonar_sequencer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // generous fixed limit, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor state: a private copy of the sequencer and its registers
    // ------------------------------------------------------------------
    logic [15:0]   scale_cfg;
    logic [3:0]    shift_cfg;
    logic [1:0]    seq_phase;
    mcss_pkg::t_ch seq_channel;
    logic          echo_seen;
    logic          capture_armed;

    mcss_pkg::t_out pending_reports_q[$];   // expected result transactions, oldest first
    int unsigned    mismatch_count = 0;

    // handshake pacing, changed per test phase
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;

    // stimulus-side bookkeeping: timer count modulo three and events that matter
    int unsigned stim_phase  = 0;
    int unsigned events_sent = 0;

    function automatic void reset_predictor();
        scale_cfg     = mcss_pkg::SCALE_RESET;
        shift_cfg     = mcss_pkg::SHIFT_RESET;
        seq_phase     = mcss_pkg::PH_LISTEN;
        seq_channel   = '0;
        echo_seen     = 1'b0;
        capture_armed = 1'b0;
    endfunction

    // step to the next transducer, flag a wrap back to the first one
    function automatic logic next_channel();
        if (int'(seq_channel) == mcss_pkg::NUM_CHANNELS - 1) begin
            seq_channel = '0;
            return 1'b1;
        end
        seq_channel = seq_channel + mcss_pkg::t_ch'(1);
        return 1'b0;
    endfunction

    // expected result of one event, updating the predictor state
    function automatic mcss_pkg::t_out predict_report(mcss_pkg::t_in ev);
        mcss_pkg::t_out r;
        logic [31:0]    product;
        logic [31:0]    scaled;
        r                = '0;
        r.report_channel = 2'(seq_channel);
        r.wait_select    = mcss_pkg::WAIT_NONE;
        if (ev.op == mcss_pkg::OP_TIMER) begin
            case (seq_phase)
                mcss_pkg::PH_LISTEN: begin
                    // end of a listen window: a silent window reports no echo
                    capture_armed = 1'b0;
                    if (!echo_seen) begin
                        r.distance_cm    = mcss_pkg::NO_ECHO_CM;
                        r.distance_valid = 1'b1;
                        r.cycle_done     = next_channel();
                    end else begin
                        echo_seen = 1'b0;
                    end
                    r.restart_echo_timer = 1'b1;
                    r.burst_on           = 1'b1;
                    r.wait_select        = mcss_pkg::WAIT_BURST;
                    seq_phase            = mcss_pkg::PH_BURST;
                end
                mcss_pkg::PH_BURST: begin
                    r.wait_select = mcss_pkg::WAIT_DECAY;
                    seq_phase     = mcss_pkg::PH_DECAY;
                end
                mcss_pkg::PH_DECAY: begin
                    capture_armed = 1'b1;
                    r.wait_select = mcss_pkg::WAIT_LISTEN;
                    seq_phase     = mcss_pkg::PH_LISTEN;
                end
                default: begin
                    r.wait_select = mcss_pkg::WAIT_LISTEN;
                    seq_phase     = mcss_pkg::PH_LISTEN;
                end
            endcase
        end else if (capture_armed) begin
            // first echo of the window: scale, shift, saturate to 255 cm
            product          = 32'(ev.capture_count) * 32'(scale_cfg);
            scaled           = product >> shift_cfg;
            capture_armed    = 1'b0;
            echo_seen        = 1'b1;
            r.distance_cm    = (scaled > 32'(mcss_pkg::NO_ECHO_CM)) ?
                               mcss_pkg::NO_ECHO_CM : scaled[7:0];
            r.distance_valid = 1'b1;
            r.cycle_done     = next_channel();
        end
        r.mux_channel = 2'(seq_channel);
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp, int unsigned act);
        if (exp != act) begin
            $error("%s expected %0d got %0d", name, exp, act);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // monitor: predicts on every accepted event, checks every accepted result
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        mcss_pkg::t_out exp_report;
        if (!i_rst_n) begin
            reset_predictor();
        end else begin
            // register writes land in the predictor at the same edge as in the block
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == mcss_pkg::REG_SCALE) scale_cfg = pwdata[15:0];
                else                                 shift_cfg = pwdata[3:0];
            end
            // push before pop so a result accepted in the same cycle as its event would still line up
            if (i_in_valid && !o_in_stall)
                pending_reports_q.push_back(predict_report(i_in_data));
            if (o_out_valid && !i_out_stall) begin
                if (pending_reports_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    mismatch_count++;
                end else begin
                    exp_report = pending_reports_q.pop_front();
                    check_field("mux_channel", exp_report.mux_channel,
                                o_out_data.mux_channel);
                    check_field("report_channel", exp_report.report_channel,
                                o_out_data.report_channel);
                    check_field("distance_cm", exp_report.distance_cm,
                                o_out_data.distance_cm);
                    check_field("distance_valid", exp_report.distance_valid,
                                o_out_data.distance_valid);
                    check_field("burst_on", exp_report.burst_on, o_out_data.burst_on);
                    check_field("wait_select", exp_report.wait_select,
                                o_out_data.wait_select);
                    check_field("restart_echo_timer", exp_report.restart_echo_timer,
                                o_out_data.restart_echo_timer);
                    check_field("cycle_done", exp_report.cycle_done,
                                o_out_data.cycle_done);
                end
            end
        end
    end

    // receiver back-pressure, independent of the block's valid
    always @(posedge i_clk)
        i_out_stall <= ($urandom_range(99) < receiver_stall_pct);

    // ------------------------------------------------------------------
    // shared drivers
    // ------------------------------------------------------------------

    // one event transaction; valid stays high afterwards so back-to-back
    // transactions need no gap
    task automatic send_event(input logic op, input logic [15:0] capture);
        mcss_pkg::t_in ev;
        ev.op            = op;
        ev.capture_count = capture;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_timer();
        send_event(mcss_pkg::OP_TIMER, 16'($urandom_range(65535)));
        stim_phase = (stim_phase == 2) ? 0 : stim_phase + 1;
        events_sent++;
    endtask

    // called straight after an accepted transaction, so valid drops in time
    task automatic stop_events();
        i_in_valid <= 1'b0;
    endtask

    // wait on the clock first so the last accepted transaction is already expected
    task automatic wait_drained();
        @(posedge i_clk);
        while (pending_reports_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mix of short windows, the extremes, single bits and full-range values
    function automatic logic [15:0] random_capture();
        case ($urandom_range(3))
            0:       return 16'($urandom_range(300));
            1:       return 16'($urandom_range(65535));
            2:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return 16'(1) << $urandom_range(15);
        endcase
    endfunction

    // one APB transfer: setup phase then access phase until pready, then idle
    task automatic reg_access(input logic reg_idx, input logic is_write,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // write both registers while idle and read them back
    task automatic set_ranging_config(input logic [15:0] scale, input logic [3:0] shift);
        logic [31:0] rdata;
        reg_access(mcss_pkg::REG_SCALE, 1'b1, 32'(scale), rdata);
        reg_access(mcss_pkg::REG_SHIFT, 1'b1, 32'(shift), rdata);
        reg_access(mcss_pkg::REG_SCALE, 1'b0, '0, rdata);
        check_field("cm_scale readback", scale, rdata[15:0]);
        reg_access(mcss_pkg::REG_SHIFT, 1'b0, '0, rdata);
        check_field("cm_shift readback", shift, rdata[3:0]);
    endtask

    // timers until the capture is armed, then mostly one echo, sometimes a
    // late echo, a missed window or a stray event that upsets the rhythm
    task automatic send_ranging_round();
        int unsigned roll;
        if ($urandom_range(99) < 6)
            send_event(mcss_pkg::OP_ECHO, random_capture());
        do send_timer(); while (stim_phase != 0);
        roll = $urandom_range(99);
        if (roll < 75) begin
            send_event(mcss_pkg::OP_ECHO, random_capture());
            events_sent++;
            if ($urandom_range(99) < 15)
                send_event(mcss_pkg::OP_ECHO, random_capture());
        end else if (roll < 82) begin
            send_timer();
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset settings (distance equals the capture), no idling on either side
    task automatic test_directed_events();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_timer();                                 // silent first window after reset: 255
        send_event(mcss_pkg::OP_ECHO, 16'd100);       // echo during the burst is ignored
        send_timer();
        send_timer();                                 // listen window armed
        send_event(mcss_pkg::OP_ECHO, 16'd0);         // shortest echo, zero distance
        send_event(mcss_pkg::OP_ECHO, 16'hFFFF);      // later echo in the same window ignored
        send_timer();                                 // window closes with an echo: no report
        send_timer();
        send_timer();
        send_event(mcss_pkg::OP_ECHO, 16'hFFFF);      // longest echo saturates
        send_timer();
        send_timer();
        send_timer();
        send_event(mcss_pkg::OP_ECHO, 16'd255);       // largest unsaturated, wraps the channel
        send_timer();
        send_timer();
        send_timer();
        send_timer();                                 // missed echo reports 255
        send_timer();
        send_timer();
        send_event(mcss_pkg::OP_ECHO, 16'd256);       // just over the limit
        send_timer();
        stop_events();
        wait_drained();
    endtask

    // register setting and pacing for one random phase
    task automatic test_random_ranging(input logic [15:0] scale, input logic [3:0] shift,
                                       input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input int unsigned n_events);
        int unsigned target;
        wait_drained();
        set_ranging_config(scale, shift);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        target             = events_sent + n_events;
        while (events_sent < target) send_ranging_round();
        stop_events();
    endtask

    // sender holds off mid-stream until every expected result has arrived
    task automatic test_pause_until_drained();
        int unsigned target;
        sender_idle_pct    = 21;
        receiver_stall_pct = 81;
        repeat (2) begin
            target = events_sent + 60;
            while (events_sent < target) send_ranging_round();
            stop_events();
            wait_drained();
        end
    endtask

    initial begin
        reset_predictor();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_events();
        test_random_ranging(mcss_pkg::SCALE_RESET, mcss_pkg::SHIFT_RESET, 0, 0, 200);
        test_random_ranging(16'd0, 4'd0, 81, 0, 180);
        test_random_ranging(16'hFFFF, 4'd15, 0, 81, 180);
        test_random_ranging(16'hFFFF, 4'd0, 21, 21, 180);
        test_random_ranging(16'd1, 4'd15, 81, 0, 150);
        test_random_ranging(16'($urandom_range(65535)), 4'($urandom_range(15)),
                            0, 81, 180);
        test_random_ranging(16'($urandom_range(1023)), 4'($urandom_range(15)),
                            21, 21, 180);
        test_random_ranging(16'd256, 4'd4, 0, 0, 150);
        test_pause_until_drained();

        wait_drained();
        if (mismatch_count == 0 && pending_reports_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
